FILE: sv/pbe_pkg.sv
// Shared types and constants for the PackBits run-length encoder.
`default_nettype none

package pbe_pkg;

  localparam int LIT_MAX = 128;
  localparam int LIT_AW  = $clog2(LIT_MAX);

  typedef enum logic [2:0] {
    SEL_LHDR,
    SEL_LBODY,
    SEL_AHDR,
    SEL_AVAL,
    SEL_BHDR,
    SEL_BVAL
  } sel_t;

  typedef struct packed {
    logic accept;
    logic emit;
    sel_t sel;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic lit_en;
    logic a_en;
    logic b_en;
    logic body_done;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/pbe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module pbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/pbe_ctrl.sv
// Controller state machine: input acceptance and coded-byte sequencing.
`default_nettype none

module pbe_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire pbe_pkg::sts_t sts,
  output pbe_pkg::cmd_t     cmd
);

  import pbe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_LHDR,
    ST_LBODY,
    ST_AHDR,
    ST_AVAL,
    ST_BHDR,
    ST_BVAL
  } state_t;

  state_t state, state_next;
  state_t after_lit, after_a;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    after_a   = sts.b_en ? ST_BHDR : ST_IDLE;
    after_lit = sts.a_en ? ST_AHDR : after_a;
  end

  always_comb begin
    cmd.accept = s_tvalid && (state == ST_IDLE);
    cmd.emit   = 1'b0;
    cmd.sel    = SEL_LHDR;
    cmd.last   = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_PLAN;
        end
      end
      ST_PLAN: begin
        state_next = sts.lit_en ? ST_LHDR : after_lit;
      end
      ST_LHDR: begin
        cmd.emit = 1'b1;
        if (sts.emit_ok) begin
          state_next = ST_LBODY;
        end
      end
      ST_LBODY: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_LBODY;
        cmd.last = sts.body_done && !sts.a_en && !sts.b_en;
        if (sts.emit_ok && sts.body_done) begin
          state_next = after_lit;
        end
      end
      ST_AHDR: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_AHDR;
        if (sts.emit_ok) begin
          state_next = ST_AVAL;
        end
      end
      ST_AVAL: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_AVAL;
        cmd.last = !sts.b_en;
        if (sts.emit_ok) begin
          state_next = after_a;
        end
      end
      ST_BHDR: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_BHDR;
        if (sts.emit_ok) begin
          state_next = ST_BVAL;
        end
      end
      ST_BVAL: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_BVAL;
        cmd.last = 1'b1;
        if (sts.emit_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/pbe_dp.sv
// Datapath: encoder state, per-transaction emission plan, byte packer, output register.
`default_nettype none

module pbe_dp #(
  parameter int MAX_RUN = 128
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [7:0]                data_byte,
  input  wire logic                      final_byte,
  input  wire pbe_pkg::cmd_t             cmd,
  output pbe_pkg::sts_t                  sts,
  output logic                           ram_we,
  output logic [pbe_pkg::LIT_AW-1:0]     ram_waddr,
  output logic [7:0]                     ram_wdata,
  output logic [pbe_pkg::LIT_AW-1:0]     ram_raddr,
  input  wire logic [7:0]                ram_q,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [31:0]                    out_word,
  output logic [2:0]                     out_count,
  output logic                           out_end
);

  import pbe_pkg::*;

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_ONE,
    PH_RUN,
    PH_LIT
  } phase_t;

  // 257 - n, modulo 256
  function automatic logic [7:0] run_code(input logic [7:0] n);
    return 8'd1 - n;
  endfunction

  phase_t            ph, ph_next;
  logic [7:0]        rb, rb_next;
  logic [LIT_AW-1:0] rl, rl_next;
  logic [LIT_AW-1:0] lc, lc_next;

  logic              lit_en, lit_en_next;
  logic [LIT_AW-1:0] lit_last, lit_last_next;
  logic              a_en, a_en_next;
  logic [7:0]        a_hdr, a_hdr_next, a_val, a_val_next;
  logic              b_en, b_en_next;
  logic [7:0]        b_hdr, b_hdr_next, b_val, b_val_next;

  logic [7:0]        k_run, k_lit;

  logic [LIT_AW-1:0] rd_idx;
  logic [7:0]        pk [3];
  logic [1:0]        pk_cnt;
  logic [7:0]        cur;
  logic [7:0]        asm_b [4];
  logic              complete, emit_ok, fire;

  // ---------------- encoder step ----------------
  always_comb begin
    k_run         = {1'b0, rl} + 8'd1;
    k_lit         = {1'b0, lc} + 8'd1;
    ph_next       = ph;
    rb_next       = rb;
    rl_next       = rl;
    lc_next       = lc;
    lit_en_next   = 1'b0;
    lit_last_next = '0;
    a_en_next     = 1'b0;
    a_hdr_next    = '0;
    a_val_next    = '0;
    b_en_next     = 1'b0;
    b_hdr_next    = '0;
    b_val_next    = '0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = data_byte;

    unique case (ph)
      PH_EMPTY: begin
        ph_next = PH_ONE;
        rb_next = data_byte;
        ram_we  = cmd.accept;
      end
      PH_ONE: begin
        if (data_byte == rb) begin
          if (MAX_RUN <= 2) begin
            a_en_next  = 1'b1;
            a_hdr_next = run_code(8'd2);
            a_val_next = data_byte;
            ph_next    = PH_EMPTY;
          end else begin
            ph_next = PH_RUN;
            rl_next = LIT_AW'(2);
          end
        end else begin
          ram_we    = cmd.accept;
          ram_waddr = LIT_AW'(1);
          lc_next   = LIT_AW'(2);
          rb_next   = data_byte;
          ph_next   = PH_LIT;
        end
      end
      PH_RUN: begin
        if (data_byte == rb) begin
          if (k_run >= 8'(MAX_RUN)) begin
            a_en_next  = 1'b1;
            a_hdr_next = run_code(k_run);
            a_val_next = data_byte;
            ph_next    = PH_EMPTY;
            rl_next    = '0;
          end else begin
            rl_next = k_run[LIT_AW-1:0];
          end
        end else begin
          a_en_next  = 1'b1;
          a_hdr_next = run_code({1'b0, rl});
          a_val_next = rb;
          rl_next    = '0;
          ph_next    = PH_ONE;
          rb_next    = data_byte;
          ram_we     = cmd.accept;
        end
      end
      PH_LIT: begin
        if (data_byte == rb) begin
          lit_en_next   = 1'b1;
          lit_last_next = lc - LIT_AW'(2);
          lc_next       = '0;
          if (MAX_RUN <= 2) begin
            a_en_next  = 1'b1;
            a_hdr_next = run_code(8'd2);
            a_val_next = data_byte;
            ph_next    = PH_EMPTY;
          end else begin
            ph_next = PH_RUN;
            rl_next = LIT_AW'(2);
          end
        end else begin
          ram_we    = cmd.accept;
          ram_waddr = lc;
          rb_next   = data_byte;
          if (k_lit >= 8'(LIT_MAX)) begin
            lit_en_next   = 1'b1;
            lit_last_next = lc;
            lc_next       = '0;
            ph_next       = PH_EMPTY;
          end else begin
            lc_next = k_lit[LIT_AW-1:0];
          end
        end
      end
      default: begin
        ph_next = PH_EMPTY;
      end
    endcase

    if (final_byte) begin
      unique case (ph_next)
        PH_ONE: begin
          b_en_next  = 1'b1;
          b_hdr_next = 8'd0;
          b_val_next = rb_next;
        end
        PH_RUN: begin
          b_en_next  = 1'b1;
          b_hdr_next = run_code({1'b0, rl_next});
          b_val_next = rb_next;
        end
        PH_LIT: begin
          lit_en_next   = 1'b1;
          lit_last_next = lc_next - LIT_AW'(1);
        end
        default: begin
        end
      endcase
      ph_next = PH_EMPTY;
      rl_next = '0;
      lc_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph     <= PH_EMPTY;
      rb     <= '0;
      rl     <= '0;
      lc     <= '0;
      lit_en <= 1'b0;
      a_en   <= 1'b0;
      b_en   <= 1'b0;
    end else if (cmd.accept) begin
      ph     <= ph_next;
      rb     <= rb_next;
      rl     <= rl_next;
      lc     <= lc_next;
      lit_en <= lit_en_next;
      a_en   <= a_en_next;
      b_en   <= b_en_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lit_last <= lit_last_next;
      a_hdr    <= a_hdr_next;
      a_val    <= a_val_next;
      b_hdr    <= b_hdr_next;
      b_val    <= b_val_next;
    end
  end

  // ---------------- emission and packing ----------------
  always_comb begin
    unique case (cmd.sel)
      SEL_LHDR:  cur = {1'b0, lit_last};
      SEL_LBODY: cur = ram_q;
      SEL_AHDR:  cur = a_hdr;
      SEL_AVAL:  cur = a_val;
      SEL_BHDR:  cur = b_hdr;
      SEL_BVAL:  cur = b_val;
      default:   cur = '0;
    endcase
  end

  assign complete = (pk_cnt == 2'd3) || cmd.last;
  assign emit_ok  = !complete || !m_tvalid || m_tready;
  assign fire     = cmd.emit && emit_ok;

  always_comb begin
    asm_b[0] = (pk_cnt == 2'd0) ? cur : pk[0];
    asm_b[1] = (pk_cnt > 2'd1) ? pk[1] : ((pk_cnt == 2'd1) ? cur : 8'd0);
    asm_b[2] = (pk_cnt > 2'd2) ? pk[2] : ((pk_cnt == 2'd2) ? cur : 8'd0);
    asm_b[3] = (pk_cnt == 2'd3) ? cur : 8'd0;
  end

  always_comb begin
    if (cmd.sel == SEL_LHDR) begin
      ram_raddr = '0;
    end else if (fire && (cmd.sel == SEL_LBODY)) begin
      ram_raddr = rd_idx + LIT_AW'(1);
    end else begin
      ram_raddr = rd_idx;
    end
  end

  always_comb begin
    sts.emit_ok   = emit_ok;
    sts.lit_en    = lit_en;
    sts.a_en      = a_en;
    sts.b_en      = b_en;
    sts.body_done = (rd_idx == lit_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pk_cnt   <= '0;
    end else begin
      if (fire && complete) begin
        m_tvalid <= 1'b1;
        pk_cnt   <= '0;
      end else begin
        if (m_tready) begin
          m_tvalid <= 1'b0;
        end
        if (fire) begin
          pk_cnt <= pk_cnt + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && complete) begin
      out_word  <= {asm_b[3], asm_b[2], asm_b[1], asm_b[0]};
      out_count <= {1'b0, pk_cnt} + 3'd1;
      out_end   <= cmd.last;
    end
    if (fire && !complete) begin
      pk[pk_cnt] <= cur;
    end
    if (fire && (cmd.sel == SEL_LHDR)) begin
      rd_idx <= '0;
    end else if (fire && (cmd.sel == SEL_LBODY)) begin
      rd_idx <= rd_idx + LIT_AW'(1);
    end
  end

  a_run_len: assert property (@(posedge clk) disable iff (rst)
    ph == PH_RUN |-> (rl >= LIT_AW'(2)) && ({1'b0, rl} < 8'(MAX_RUN)))
    else $error("run length out of range");

  a_lit_len: assert property (@(posedge clk) disable iff (rst)
    ph == PH_LIT |-> lc >= LIT_AW'(2))
    else $error("literal shorter than two bytes");

  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    ph == PH_EMPTY |-> (rl == '0) && (lc == '0))
    else $error("empty phase with pending counts");

  a_final_flush: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && final_byte |=> ph == PH_EMPTY)
    else $error("final byte did not flush");

endmodule

`default_nettype wire

FILE: sv/packbits_rle_encoder_top.sv
// Top level of the PackBits run-length encoder: stream ports, controller, datapath, literal RAM.
`default_nettype none

// PackBits encoder: one raw byte per input transaction (tlast marks the stream's final byte,
// which flushes all pending data), coded bytes packed four per output transaction in
// stream order, with tlast on the last output caused by an input. An input that causes no
// output passes through the accept and plan states. One that causes output also has its
// coded bytes moved by the sequencer, one coded byte per cycle unless stalled; literal
// bytes come from a 128-entry RAM through its single registered read port. Output back-
// pressure stalls the sequencer only when a word completes while the previous one still waits.
module packbits_rle_encoder_top #(
  parameter int MAX_RUN = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // final_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [7:0] out_byte_0, [15:8] out_byte_1,
                                      // [23:16] out_byte_2, [31:24] out_byte_3,
                                      // [34:32] byte_count, [39:35] zero
  output logic             m_tlast    // burst_end
);

  import pbe_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic              ram_we;
  logic [LIT_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_q;
  logic [31:0]       out_word;
  logic [2:0]        out_count;

  pbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbe_dp #(
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (s_tdata),
    .final_byte (s_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_q      (ram_q),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_word   (out_word),
    .out_count  (out_count),
    .out_end    (m_tlast)
  );

  pbe_ram #(
    .WIDTH (8),
    .DEPTH (LIT_MAX)
  ) u_lit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign m_tdata = {5'd0, out_count, out_word};

endmodule

`default_nettype wire

FILE: verif/packbits_rle_encoder_top_test.sv
// Testbench for packbits_rle_encoder_top: directed and random streams against a predictor.
module packbits_rle_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RUN     = 128;
  localparam int LIT_MAX     = pbe_pkg::LIT_MAX;
  localparam int IDLE_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 160;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {ENC_EMPTY, ENC_ONE, ENC_RUN, ENC_LIT} enc_phase_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            burst_end;
  } coded_word_t;

  typedef logic [7:0] raw_q_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  // encoder state mirror
  enc_phase_t  enc_phase = ENC_EMPTY;
  logic [7:0]  last_byte = '0;
  int          run_len = 0;
  logic [7:0]  lit_buf[LIT_MAX];
  int          lit_len = 0;

  logic [7:0]  coded_bytes[$];
  coded_word_t pending_words[$];

  int          errors = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  int          rx_hold_cycles = 0;
  bit          no_idle = 1'b0;

  packbits_rle_encoder_top #(.MAX_RUN(MAX_RUN)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5ns clk = ~clk;

  function automatic void put_run(input int n, input logic [7:0] v);
    coded_bytes.push_back(8'(257 - n));
    coded_bytes.push_back(v);
  endfunction

  function automatic void put_literal(input int n);
    if (n == 0) return;
    coded_bytes.push_back(8'(n - 1));
    for (int i = 0; i < n; i++) coded_bytes.push_back(lit_buf[i]);
  endfunction

  function automatic void go_empty();
    enc_phase = ENC_EMPTY;
    run_len = 0;
    lit_len = 0;
  endfunction

  function automatic void start_pair(input logic [7:0] b);
    if (MAX_RUN <= 2) begin
      put_run(2, b);
      go_empty();
    end else begin
      enc_phase = ENC_RUN;
      run_len = 2;
    end
  endfunction

  // advance the encoder mirror by one raw byte and queue the coded words it yields
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    int k;
    int nres;
    int cnt;
    coded_word_t w;
    coded_bytes.delete();
    case (enc_phase)
      ENC_EMPTY: begin
        enc_phase = ENC_ONE;
        last_byte = b;
      end
      ENC_ONE: begin
        if (b == last_byte) begin
          start_pair(b);
        end else begin
          lit_buf[0] = last_byte;
          lit_buf[1] = b;
          lit_len = 2;
          last_byte = b;
          enc_phase = ENC_LIT;
        end
      end
      ENC_RUN: begin
        if (b == last_byte) begin
          k = run_len + 1;
          if (k >= MAX_RUN) begin
            put_run(k, b);
            go_empty();
          end else begin
            run_len = k;
          end
        end else begin
          put_run(run_len, last_byte);
          run_len = 0;
          enc_phase = ENC_ONE;
          last_byte = b;
        end
      end
      default: begin
        k = (lit_len > LIT_MAX - 1) ? LIT_MAX - 1 : lit_len;
        if (b == last_byte) begin
          // pair closes the literal and opens a run
          put_literal(k - 1);
          lit_len = 0;
          start_pair(b);
        end else begin
          lit_buf[k] = b;
          k++;
          last_byte = b;
          if (k >= LIT_MAX) begin
            put_literal(k);
            go_empty();
          end else begin
            lit_len = k;
          end
        end
      end
    endcase

    if (fin) begin
      case (enc_phase)
        ENC_ONE: begin
          coded_bytes.push_back(8'h00);
          coded_bytes.push_back(last_byte);
        end
        ENC_RUN: put_run(run_len, last_byte);
        ENC_LIT: put_literal(lit_len);
        default: ;
      endcase
      go_empty();
    end

    nres = (coded_bytes.size() + 3) / 4;
    for (int i = 0; i < nres; i++) begin
      w = '0;
      cnt = coded_bytes.size() - 4 * i;
      if (cnt > 4) cnt = 4;
      for (int j = 0; j < cnt; j++) w.bytes[j] = coded_bytes[4 * i + j];
      w.cnt = 3'(cnt);
      w.burst_end = (i == nres - 1);
      pending_words.push_back(w);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!no_idle && $urandom_range(0, 99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    encode_byte(b, fin);
    items_sent++;
  endtask

  task automatic send_stream(input raw_q_t q, input bit fin_at_end);
    for (int i = 0; i < q.size(); i++)
      send_byte(q[i], fin_at_end && (i == q.size() - 1));
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed_cases();
    send_stream('{8'h00}, 1'b1);
    send_stream('{8'hff}, 1'b1);
    send_stream('{8'h55, 8'h55}, 1'b1);
    send_stream('{8'haa, 8'haa, 8'haa, 8'h01}, 1'b1);
    send_stream('{8'h01, 8'h02, 8'h03}, 1'b1);
    send_stream('{8'h10, 8'h20, 8'h20}, 1'b1);
    send_stream('{8'h7f, 8'h80, 8'h80, 8'h80, 8'h3c, 8'h3d}, 1'b1);
  endtask

  task automatic run_max_run();
    raw_q_t q;
    for (int i = 0; i < MAX_RUN + 2; i++) q.push_back(8'h3c);
    send_stream(q, 1'b1);
  endtask

  task automatic run_max_literal();
    raw_q_t q;
    for (int i = 0; i < LIT_MAX; i++) q.push_back(8'(i));
    send_stream(q, 1'b0);
  endtask

  task automatic run_output_stall();
    raw_q_t q;
    rx_hold_cycles = 400;
    // short runs of two, each break yields a result
    for (int i = 0; i < 40; i++) q.push_back(8'((i >> 1) * 7 + 1));
    send_stream(q, 1'b1);
    s_tvalid <= 1'b0;
    wait_drained();
  endtask

  task automatic run_random_streams();
    raw_q_t     q;
    int         mode;
    int         len;
    int         r;
    int         target;
    bit         paused;
    logic [7:0] prev;
    logic [7:0] b;
    target = items_sent + RANDOM_ITEMS;
    paused = 1'b0;
    while (items_sent < target) begin
      q.delete();
      mode = $urandom_range(0, 15);
      prev = 8'($urandom);
      if (mode == 0) begin
        len = $urandom_range(100, 260);
        for (int i = 0; i < len; i++) q.push_back(prev);
      end else if (mode == 1) begin
        len = $urandom_range(100, 200);
        for (int i = 0; i < len; i++) begin
          prev = prev + 8'($urandom_range(1, 255));
          q.push_back(prev);
        end
      end else begin
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          if (i > 0 && r < 40) b = prev;
          else if (r < 55) b = 8'($urandom_range(0, 3));
          else b = 8'($urandom);
          q.push_back(b);
          prev = b;
        end
      end
      while (q.size() > target - items_sent) void'(q.pop_back());
      no_idle = (items_sent > target - RANDOM_ITEMS + 40) &&
                (items_sent < target - RANDOM_ITEMS + 110);
      send_stream(q, $urandom_range(0, 9) != 0);
      if (!paused && items_sent > target - RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        wait_drained();
      end
    end
    no_idle = 1'b0;
    // close any open stream
    send_byte(8'($urandom), 1'b1);
  endtask

  // receiver: random ready, forced hold-off, result checking
  initial begin
    coded_word_t w;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (pending_words.size() == 0) begin
          $error("output transaction with no expected result: tdata=%h tlast=%b",
                 m_tdata, m_tlast);
          errors++;
        end else begin
          w = pending_words.pop_front();
          for (int j = 0; j < 4; j++)
            if (m_tdata[8 * j +: 8] !== w.bytes[j]) begin
              $error("out_byte_%0d: expected %h, actual %h", j, w.bytes[j],
                     m_tdata[8 * j +: 8]);
              errors++;
            end
          if (m_tdata[34:32] !== w.cnt) begin
            $error("byte_count: expected %0d, actual %0d", w.cnt, m_tdata[34:32]);
            errors++;
          end
          if (m_tlast !== w.burst_end) begin
            $error("burst_end: expected %b, actual %b", w.burst_end, m_tlast);
            errors++;
          end
        end
      end
      if (rx_hold_cycles > 0) begin
        m_tready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed_cases();
    run_max_run();
    run_max_literal();
    run_output_stall();
    run_random_streams();
    s_tvalid <= 1'b0;
    wait_drained();
    if (errors == 0 && pending_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
